// File: src/point_gravity_body_step_assert.svh
// Assertion macros for the point gravity body step checker.
// Included by the checker file; needs a clock named clk and a reset named rst.
`ifndef POINT_GRAVITY_BODY_STEP_ASSERT_SVH
`define POINT_GRAVITY_BODY_STEP_ASSERT_SVH

// Same-cycle implication.
`define PGBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PGBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pgbs_pkg.sv
// Shared constants, command codes and control types for the gravity step.
// No dependencies.
`default_nettype none
package pgbs_pkg;

  localparam int MAX_CENTERS_DEF = 8;

  localparam int POS_W     = 32;
  localparam int GM_W      = 31;
  localparam int TS_W      = 17;
  localparam int SR_W      = 16;
  localparam int OUT_CNT_W = 4;
  localparam int MAG_W     = 32;
  localparam int SUM_W     = 66;
  localparam int ROOT_W    = 33;
  localparam int NUM_W     = 64;
  localparam int ENTRY_W   = 3 * POS_W + GM_W;

  localparam int SQRT_ITERS = ROOT_W;
  localparam int DIV_ITERS  = NUM_W;
  localparam int ITER_W     = 7;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  localparam logic [TS_W-1:0] TS_RESET = 17'd3277;
  localparam logic [SR_W-1:0] SR_RESET = 16'd66;

  localparam logic REG_TS = 1'b0;
  localparam logic REG_SR = 1'b1;

  localparam logic [4:0] CMD_NOP       = 5'd0;
  localparam logic [4:0] CMD_ACCEPT    = 5'd1;
  localparam logic [4:0] CMD_START     = 5'd2;
  localparam logic [4:0] CMD_READ      = 5'd3;
  localparam logic [4:0] CMD_DIFF      = 5'd4;
  localparam logic [4:0] CMD_SQMUL     = 5'd5;
  localparam logic [4:0] CMD_SQADD     = 5'd6;
  localparam logic [4:0] CMD_ROOTINIT  = 5'd7;
  localparam logic [4:0] CMD_ROOTSTEP  = 5'd8;
  localparam logic [4:0] CMD_SKIP      = 5'd9;
  localparam logic [4:0] CMD_DIV1LOAD  = 5'd10;
  localparam logic [4:0] CMD_DIVSTEP   = 5'd11;
  localparam logic [4:0] CMD_DIV2LOAD  = 5'd12;
  localparam logic [4:0] CMD_CLAMP     = 5'd13;
  localparam logic [4:0] CMD_PMUL      = 5'd14;
  localparam logic [4:0] CMD_PDIVLOAD  = 5'd15;
  localparam logic [4:0] CMD_PACC      = 5'd16;
  localparam logic [4:0] CMD_NEXT      = 5'd17;
  localparam logic [4:0] CMD_AMUL      = 5'd18;
  localparam logic [4:0] CMD_VADD      = 5'd19;
  localparam logic [4:0] CMD_VMUL      = 5'd20;
  localparam logic [4:0] CMD_PADD      = 5'd21;
  localparam logic [4:0] CMD_OUT       = 5'd22;

  typedef struct packed {
    logic [4:0] code;
    logic [1:0] axis;
  } pgbs_cmd_t;

  typedef struct packed {
    logic step_item;
    logic at_end;
    logic skip;
  } pgbs_stat_t;

endpackage
`default_nettype wire

// File: src/point_gravity_body_step.sv
// Top level of the point gravity body step: controller, datapath, APB registers.
// Depends on pgbs_pkg, pgbs_regs, pgbs_ctrl, pgbs_datapath.
//
// Clear and append items are handled in the idle state and leave the input ready. A body
// step walks the center table one center at a time through a shared 32x32 multiplier, a
// one-bit-per-cycle square root and a one-bit-per-cycle divider (used five times per
// center that is not skipped). Items are taken one at a time; a finished result waits in
// the output register while the next item is accepted.
`default_nettype none
module point_gravity_body_step
  import pgbs_pkg::*;
#(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              operation,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic signed [POS_W-1:0] vel_x,
  input  wire logic signed [POS_W-1:0] vel_y,
  input  wire logic signed [POS_W-1:0] vel_z,
  input  wire logic [GM_W-1:0]         strength,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [POS_W-1:0]      new_pos_x,
  output logic signed [POS_W-1:0]      new_pos_y,
  output logic signed [POS_W-1:0]      new_pos_z,
  output logic signed [POS_W-1:0]      new_vel_x,
  output logic signed [POS_W-1:0]      new_vel_y,
  output logic signed [POS_W-1:0]      new_vel_z,
  output logic [OUT_CNT_W-1:0]         centers_used
);

  logic [TS_W-1:0] time_step;
  logic [SR_W-1:0] softening_radius;
  pgbs_cmd_t       cmd;
  pgbs_stat_t      stat;

  pgbs_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .time_step, .softening_radius
  );

  pgbs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  pgbs_datapath #(.MAX_CENTERS(MAX_CENTERS)) u_dp (
    .clk, .rst, .cmd, .stat, .time_step, .softening_radius, .operation,
    .pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z, .strength,
    .new_pos_x, .new_pos_y, .new_pos_z, .new_vel_x, .new_vel_y, .new_vel_z,
    .centers_used
  );

endmodule
`default_nettype wire

// File: src/pgbs_regs.sv
// APB configuration registers: time step and softening radius.
// Depends on pgbs_pkg.
`default_nettype none
module pgbs_regs
  import pgbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [TS_W-1:0]  time_step,
  output logic      [SR_W-1:0]  softening_radius
);

  logic wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step        <= TS_RESET;
      softening_radius <= SR_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_TS: time_step        <= pwdata[TS_W-1:0];
        REG_SR: softening_radius <= pwdata[SR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TS:  prdata = {{(32-TS_W){1'b0}}, time_step};
      REG_SR:  prdata = {{(32-SR_W){1'b0}}, softening_radius};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/pgbs_ctrl.sv
// Controller state machine: sequences the datapath and owns the handshakes.
// Depends on pgbs_pkg.
`default_nettype none
module pgbs_ctrl
  import pgbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire pgbs_stat_t stat,
  output pgbs_cmd_t       cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_START  = 5'd1;
  localparam logic [4:0] ST_LOOP   = 5'd2;
  localparam logic [4:0] ST_DIFF   = 5'd3;
  localparam logic [4:0] ST_SQMUL  = 5'd4;
  localparam logic [4:0] ST_SQADD  = 5'd5;
  localparam logic [4:0] ST_RINIT  = 5'd6;
  localparam logic [4:0] ST_ROOT   = 5'd7;
  localparam logic [4:0] ST_CHK    = 5'd8;
  localparam logic [4:0] ST_DIV1   = 5'd9;
  localparam logic [4:0] ST_DIV2L  = 5'd10;
  localparam logic [4:0] ST_DIV2   = 5'd11;
  localparam logic [4:0] ST_CLAMP  = 5'd12;
  localparam logic [4:0] ST_PMUL   = 5'd13;
  localparam logic [4:0] ST_PDL    = 5'd14;
  localparam logic [4:0] ST_PDIV   = 5'd15;
  localparam logic [4:0] ST_PACC   = 5'd16;
  localparam logic [4:0] ST_NEXT   = 5'd17;
  localparam logic [4:0] ST_AMUL   = 5'd18;
  localparam logic [4:0] ST_VADD   = 5'd19;
  localparam logic [4:0] ST_VMUL   = 5'd20;
  localparam logic [4:0] ST_PADD   = 5'd21;
  localparam logic [4:0] ST_DONE   = 5'd22;

  localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(SQRT_ITERS - 1);
  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_ITERS - 1);

  logic [4:0]        state, state_next;
  logic [1:0]        axis, axis_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    iter_next      = iter;
    cmd.code       = CMD_NOP;
    cmd.axis       = axis;
    out_valid_next = out_ready ? 1'b0 : out_valid;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.code = CMD_ACCEPT;
          if (stat.step_item) state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.code   = CMD_START;
        state_next = ST_LOOP;
      end
      ST_LOOP: begin
        axis_next = 2'd0;
        if (stat.at_end) begin
          state_next = ST_AMUL;
        end else begin
          cmd.code   = CMD_READ;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.code   = CMD_DIFF;
        state_next = ST_SQMUL;
      end
      ST_SQMUL: begin
        cmd.code   = CMD_SQMUL;
        state_next = ST_SQADD;
      end
      ST_SQADD: begin
        cmd.code = CMD_SQADD;
        if (axis == 2'd2) begin
          axis_next  = 2'd0;
          state_next = ST_RINIT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_SQMUL;
        end
      end
      ST_RINIT: begin
        cmd.code   = CMD_ROOTINIT;
        iter_next  = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.code  = CMD_ROOTSTEP;
        iter_next = iter + 1'b1;
        if (iter == ROOT_LAST) state_next = ST_CHK;
      end
      ST_CHK: begin
        iter_next = '0;
        if (stat.skip) begin
          cmd.code   = CMD_SKIP;
          state_next = ST_LOOP;
        end else begin
          cmd.code   = CMD_DIV1LOAD;
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: begin
        cmd.code  = CMD_DIVSTEP;
        iter_next = iter + 1'b1;
        if (iter == DIV_LAST) state_next = ST_DIV2L;
      end
      ST_DIV2L: begin
        cmd.code   = CMD_DIV2LOAD;
        iter_next  = '0;
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.code  = CMD_DIVSTEP;
        iter_next = iter + 1'b1;
        if (iter == DIV_LAST) state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.code   = CMD_CLAMP;
        axis_next  = 2'd0;
        state_next = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.code   = CMD_PMUL;
        state_next = ST_PDL;
      end
      ST_PDL: begin
        cmd.code   = CMD_PDIVLOAD;
        iter_next  = '0;
        state_next = ST_PDIV;
      end
      ST_PDIV: begin
        cmd.code  = CMD_DIVSTEP;
        iter_next = iter + 1'b1;
        if (iter == DIV_LAST) state_next = ST_PACC;
      end
      ST_PACC: begin
        cmd.code = CMD_PACC;
        if (axis == 2'd2) begin
          state_next = ST_NEXT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_PMUL;
        end
      end
      ST_NEXT: begin
        cmd.code   = CMD_NEXT;
        state_next = ST_LOOP;
      end
      ST_AMUL: begin
        cmd.code   = CMD_AMUL;
        state_next = ST_VADD;
      end
      ST_VADD: begin
        cmd.code   = CMD_VADD;
        state_next = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.code   = CMD_VMUL;
        state_next = ST_PADD;
      end
      ST_PADD: begin
        cmd.code = CMD_PADD;
        if (axis == 2'd2) begin
          state_next = ST_DONE;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_AMUL;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.code       = CMD_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 2'd0;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: src/pgbs_datapath.sv
// Datapath: center table, shared multiplier, serial square root and divider,
// accumulators and output registers. Depends on pgbs_pkg.
`default_nettype none
module pgbs_datapath
  import pgbs_pkg::*;
#(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pgbs_cmd_t               cmd,
  output pgbs_stat_t                   stat,
  input  wire logic [TS_W-1:0]         time_step,
  input  wire logic [SR_W-1:0]         softening_radius,
  input  wire logic [1:0]              operation,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic signed [POS_W-1:0] vel_x,
  input  wire logic signed [POS_W-1:0] vel_y,
  input  wire logic signed [POS_W-1:0] vel_z,
  input  wire logic [GM_W-1:0]         strength,
  output logic signed [POS_W-1:0]      new_pos_x,
  output logic signed [POS_W-1:0]      new_pos_y,
  output logic signed [POS_W-1:0]      new_pos_z,
  output logic signed [POS_W-1:0]      new_vel_x,
  output logic signed [POS_W-1:0]      new_vel_y,
  output logic signed [POS_W-1:0]      new_vel_z,
  output logic [OUT_CNT_W-1:0]         centers_used
);

  localparam int CNT_W  = $clog2(MAX_CENTERS + 1);
  localparam int IDX_W  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int UW     = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam int ACC_W  = 33 + CNT_W;
  localparam int DTP_W  = ACC_W + TS_W;
  localparam int SC_W   = DTP_W - 16;
  localparam int SW     = ACC_W + 3;
  localparam int REM_W  = ROOT_W + 1;

  logic [ENTRY_W-1:0] mem [MAX_CENTERS];
  logic [ENTRY_W-1:0] mem_q;

  logic [CNT_W-1:0] count, idx, used;

  logic signed [POS_W-1:0] px [3];
  logic signed [POS_W-1:0] vx [3];
  logic signed [POS_W-1:0] cpos [3];
  logic signed [POS_W-1:0] nv [3];
  logic signed [POS_W-1:0] np [3];
  logic [MAG_W-1:0]        dmag [3];
  logic [2:0]              dneg;

  logic [2*MAG_W-1:0] prod, mprod;
  logic [MAG_W-1:0]   mul_a;
  logic [SUM_W-1:0]   sum;
  logic [ROOT_W-1:0]  root;
  logic [REM_W-1:0]   rrem;
  logic [REM_W+1:0]   r4, trial;
  logic [NUM_W-1:0]   div_num;
  logic [ROOT_W-1:0]  div_rem;
  logic [ROOT_W:0]    dshift;
  logic [MAG_W-1:0]   mval;

  logic signed [ACC_W-1:0] acc [3];
  logic [ACC_W-1:0]        amag;
  logic [MAG_W-1:0]        nvmag;
  logic [DTP_W-1:0]        dtp, aprod;
  logic [48:0]             vprod;
  logic                    dtneg;
  logic [SC_W-1:0]         sc;
  logic signed [SW-1:0]    sc_s;
  logic [UW-1:0]           used_ext;
  logic                    append_ok;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SW-1:0] v);
    logic fits;
    fits = (&v[SW-1:POS_W-1]) | ~(|v[SW-1:POS_W-1]);
    if (fits) return v[POS_W-1:0];
    return v[SW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  assign cpos[0] = mem_q[ENTRY_W-1 -: POS_W];
  assign cpos[1] = mem_q[ENTRY_W-1-POS_W -: POS_W];
  assign cpos[2] = mem_q[ENTRY_W-1-2*POS_W -: POS_W];

  assign stat.step_item = (operation == OP_STEP);
  assign stat.at_end    = (idx == count);
  assign stat.skip      = (root <= {{(ROOT_W-SR_W){1'b0}}, softening_radius});

  assign append_ok = (cmd.code == CMD_ACCEPT) && (operation == OP_APPEND) &&
                     (count < CNT_W'(MAX_CENTERS));

  assign mul_a = (cmd.code == CMD_PMUL) ? mval : dmag[cmd.axis];
  assign mprod = (2*MAG_W)'(mul_a) * (2*MAG_W)'(dmag[cmd.axis]);

  assign r4     = {rrem, sum[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign dshift = {div_rem, div_num[NUM_W-1]};

  assign amag  = acc[cmd.axis][ACC_W-1] ? ACC_W'(-acc[cmd.axis]) : ACC_W'(acc[cmd.axis]);
  assign aprod = DTP_W'(amag) * DTP_W'(time_step);
  assign nvmag = nv[cmd.axis][POS_W-1] ? MAG_W'(-nv[cmd.axis]) : MAG_W'(nv[cmd.axis]);
  assign vprod = 49'(nvmag) * 49'(time_step);
  assign sc    = dtp[DTP_W-1:16];
  assign sc_s  = dtneg ? -signed'({2'b00, sc}) : signed'({2'b00, sc});

  always_ff @(posedge clk) begin
    if (append_ok) mem[count[IDX_W-1:0]] <= {pos_x, pos_y, pos_z, strength};
    if (cmd.code == CMD_READ) mem_q <= mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.code == CMD_ACCEPT && operation == OP_CLEAR) begin
      count <= '0;
    end else if (append_ok) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.code)
      CMD_ACCEPT: begin
        px[0] <= pos_x; px[1] <= pos_y; px[2] <= pos_z;
        vx[0] <= vel_x; vx[1] <= vel_y; vx[2] <= vel_z;
      end
      CMD_START: begin
        idx  <= '0;
        used <= '0;
        for (int k = 0; k < 3; k++) acc[k] <= '0;
      end
      CMD_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          logic signed [POS_W:0] d;
          d = {cpos[k][POS_W-1], cpos[k]} - {px[k][POS_W-1], px[k]};
          dneg[k] <= d[POS_W];
          dmag[k] <= d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
        end
        sum <= '0;
      end
      CMD_SQMUL, CMD_PMUL: prod <= mprod;
      CMD_SQADD: sum <= sum + SUM_W'(prod);
      CMD_ROOTINIT: begin
        rrem <= '0;
        root <= '0;
      end
      CMD_ROOTSTEP: begin
        if (r4 >= trial) begin
          rrem <= REM_W'(r4 - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rrem <= REM_W'(r4);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        sum <= {sum[SUM_W-3:0], 2'b00};
      end
      CMD_SKIP: idx <= idx + 1'b1;
      CMD_DIV1LOAD: begin
        div_num <= {1'b0, mem_q[GM_W-1:0], 32'b0};
        div_rem <= '0;
      end
      CMD_DIVSTEP: begin
        if (dshift >= {1'b0, root}) begin
          div_rem <= ROOT_W'(dshift - {1'b0, root});
          div_num <= {div_num[NUM_W-2:0], 1'b1};
        end else begin
          div_rem <= dshift[ROOT_W-1:0];
          div_num <= {div_num[NUM_W-2:0], 1'b0};
        end
      end
      CMD_DIV2LOAD: div_rem <= '0;
      CMD_CLAMP: begin
        if (div_num > NUM_W'(64'h8000_0000)) mval <= 32'h8000_0000;
        else mval <= div_num[MAG_W-1:0];
      end
      CMD_PDIVLOAD: begin
        div_num <= prod;
        div_rem <= '0;
      end
      CMD_PACC: begin
        if (dneg[cmd.axis])
          acc[cmd.axis] <= acc[cmd.axis] - signed'(ACC_W'(div_num[MAG_W-1:0]));
        else
          acc[cmd.axis] <= acc[cmd.axis] + signed'(ACC_W'(div_num[MAG_W-1:0]));
      end
      CMD_NEXT: begin
        idx  <= idx + 1'b1;
        used <= used + 1'b1;
      end
      CMD_AMUL: begin
        dtp   <= aprod;
        dtneg <= acc[cmd.axis][ACC_W-1];
      end
      CMD_VADD: nv[cmd.axis] <= sat32(SW'(vx[cmd.axis]) + sc_s);
      CMD_VMUL: begin
        dtp   <= DTP_W'(vprod);
        dtneg <= nv[cmd.axis][POS_W-1];
      end
      CMD_PADD: np[cmd.axis] <= sat32(SW'(px[cmd.axis]) + sc_s);
      CMD_OUT: begin
        new_pos_x    <= np[0];
        new_pos_y    <= np[1];
        new_pos_z    <= np[2];
        new_vel_x    <= nv[0];
        new_vel_y    <= nv[1];
        new_vel_z    <= nv[2];
        centers_used <= used_ext[OUT_CNT_W-1:0];
      end
      default: ;
    endcase
  end

  assign used_ext = UW'(used);

endmodule
`default_nettype wire

// File: src/pgbs_checker.sv
// Port-level checker for the gravity step, bound to the top level.
// Depends on pgbs_pkg and point_gravity_body_step_assert.svh.
`default_nettype none
`include "point_gravity_body_step_assert.svh"
module pgbs_checker
  import pgbs_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    pready,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [1:0]              operation,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [POS_W-1:0] new_pos_x
);

  `PGBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_pos_x), "result dropped or changed while stalled")
  `PGBS_ASSERT_NEXT(a_step_busy, in_valid && in_ready && operation == OP_STEP, !in_ready, "body step did not occupy the block")
  `PGBS_ASSERT_NEXT(a_table_op_quick, in_valid && in_ready && operation != OP_STEP, in_ready, "table item stalled the input")
  `PGBS_ASSERT_NOW(a_result_idle, $rose(out_valid), in_ready, "result shown while still busy")
  `PGBS_ASSERT_NOW(a_pready, 1'b1, pready, "pready low")

endmodule

bind point_gravity_body_step pgbs_checker u_pgbs_checker (
  .clk, .rst, .pready, .in_valid, .in_ready, .operation, .out_valid, .out_ready,
  .new_pos_x
);
`default_nettype wire

// File: bench/gravity_checker.sv
// Checker for the point gravity body step: watches the register port and both item channels,
// keeps its own center table and predicts each body step, compares results field by field.
// Depends on pgbs_pkg.
module gravity_checker
  import pgbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              operation,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic signed [POS_W-1:0] vel_x,
  input  logic signed [POS_W-1:0] vel_y,
  input  logic signed [POS_W-1:0] vel_z,
  input  logic [GM_W-1:0]         strength,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [POS_W-1:0] new_pos_x,
  input  logic signed [POS_W-1:0] new_pos_y,
  input  logic signed [POS_W-1:0] new_pos_z,
  input  logic signed [POS_W-1:0] new_vel_x,
  input  logic signed [POS_W-1:0] new_vel_y,
  input  logic signed [POS_W-1:0] new_vel_z,
  input  logic [OUT_CNT_W-1:0]    centers_used,
  output int                      mismatches,
  output int                      bodies_pending,
  output int                      bodies_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NC = MAX_CENTERS_DEF;

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [3:0]  used;
  } body_state_t;

  logic signed [31:0] ctr_x [NC];
  logic signed [31:0] ctr_y [NC];
  logic signed [31:0] ctr_z [NC];
  logic [30:0]        ctr_gm [NC];
  int                 ctr_count;
  logic [TS_W-1:0]    step_dt;
  logic [SR_W-1:0]    skip_radius;
  body_state_t        moved_bodies[$];

  function automatic longint scale_by_dt(longint v);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * longint'(step_dt)) >> 16;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] sq);
    logic [127:0] y, c;
    y = 0;
    for (int b = 34; b >= 0; b--) begin
      c = y | (128'd1 << b);
      if (c * c <= sq) y = c;
    end
    return y[63:0];
  endfunction

  function automatic body_state_t move_body(longint p[3], longint v[3]);
    body_state_t r;
    longint acc[3], d[3], nv, np;
    logic [63:0] m[3], rad, pull, part, num;
    logic [127:0] sq;
    int used;
    acc = '{0, 0, 0};
    used = 0;
    for (int i = 0; i < ctr_count; i++) begin
      d[0] = longint'(ctr_x[i]) - p[0];
      d[1] = longint'(ctr_y[i]) - p[1];
      d[2] = longint'(ctr_z[i]) - p[2];
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        m[k] = (d[k] < 0) ? -d[k] : d[k];
        sq += {64'd0, m[k]} * {64'd0, m[k]};
      end
      rad = floor_root(sq);
      if (rad <= skip_radius) continue;
      num = {1'b0, ctr_gm[i], 32'd0};
      pull = (num / rad) / rad;
      if (pull > 64'h8000_0000) pull = 64'h8000_0000;
      for (int k = 0; k < 3; k++) begin
        part = (pull * m[k]) / rad;
        acc[k] += (d[k] < 0) ? -longint'(part) : longint'(part);
      end
      used++;
    end
    for (int k = 0; k < 3; k++) begin
      nv = clip32(v[k] + scale_by_dt(acc[k]));
      np = clip32(p[k] + scale_by_dt(nv));
      if (k == 0) begin r.px = np[31:0]; r.vx = nv[31:0]; end
      if (k == 1) begin r.py = np[31:0]; r.vy = nv[31:0]; end
      if (k == 2) begin r.pz = np[31:0]; r.vz = nv[31:0]; end
    end
    r.used = used[3:0];
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    longint p[3], v[3];
    body_state_t e;
    int bad;
    if (rst) begin
      ctr_count <= 0;
      step_dt <= TS_RESET;
      skip_radius <= SR_RESET;
      moved_bodies.delete();
      mismatches <= 0;
      bodies_pending <= 0;
      bodies_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TS) step_dt <= pwdata[TS_W-1:0];
        else skip_radius <= pwdata[SR_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (operation == OP_CLEAR) begin
          ctr_count <= 0;
        end else if (operation == OP_APPEND) begin
          if (ctr_count < NC) begin
            ctr_x[ctr_count] <= pos_x;
            ctr_y[ctr_count] <= pos_y;
            ctr_z[ctr_count] <= pos_z;
            ctr_gm[ctr_count] <= strength;
            ctr_count <= ctr_count + 1;
          end
        end else if (operation == OP_STEP) begin
          p = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
          v = '{longint'(vel_x), longint'(vel_y), longint'(vel_z)};
          e = move_body(p, v);
          moved_bodies = {moved_bodies, e};
        end
      end
      if (out_valid && out_ready) begin
        if (moved_bodies.size() == 0) begin
          $error("result item with no body step waiting");
          mismatches <= mismatches + 1;
        end else begin
          e = moved_bodies.pop_front();
          bad = field_diff("new_pos_x", e.px, new_pos_x)
              + field_diff("new_pos_y", e.py, new_pos_y)
              + field_diff("new_pos_z", e.pz, new_pos_z)
              + field_diff("new_vel_x", e.vx, new_vel_x)
              + field_diff("new_vel_y", e.vy, new_vel_y)
              + field_diff("new_vel_z", e.vz, new_vel_z)
              + field_diff("centers_used", {28'd0, e.used}, {28'd0, centers_used});
          mismatches <= mismatches + bad;
          bodies_checked <= bodies_checked + 1;
        end
      end
      bodies_pending <= moved_bodies.size();
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the point gravity body step bench: clock, reset, register writes, item stimulus.
// Depends on pgbs_pkg, point_gravity_body_step and gravity_checker.
module testbench
  import pgbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic [1:0] operation = OP_CLEAR;
  logic signed [POS_W-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [POS_W-1:0] vel_x = 0, vel_y = 0, vel_z = 0;
  logic [GM_W-1:0] strength = 0;
  logic out_valid, out_ready = 0;
  logic signed [POS_W-1:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic [OUT_CNT_W-1:0] centers_used;
  int mismatches, bodies_pending, bodies_checked;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0, hold_len = 0;
  int table_fill = 0;
  int items_sent = 0;

  always #2 clk = ~clk;

  point_gravity_body_step dut (.*);

  gravity_checker chk (.*);

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= hold_len;
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send(logic [1:0] op, logic [31:0] px, py, pz, vx, vy, vz, logic [30:0] gm);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1; operation <= op;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    vel_x <= vx; vel_y <= vy; vel_z <= vz;
    strength <= gm;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_CLEAR) table_fill = 0;
    if (op == OP_APPEND && table_fill < MAX_CENTERS_DEF) table_fill++;
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (bodies_pending != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(32'h0040_0000) - 32'h0020_0000;
  endfunction

  function automatic logic [30:0] rand_gm();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(31'h7fff));
      default: return 31'($urandom_range(31'h00ff_ffff));
    endcase
  endfunction

  task automatic random_item(int cap);
    int r;
    r = $urandom_range(99);
    if (r < 5)
      send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           31'($urandom));
    else if (r < 12 || (table_fill >= cap && r < 20))
      send(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0, 0);
    else if (r < 40 && table_fill < cap)
      send(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0, rand_gm());
    else
      send(OP_STEP, rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), 31'($urandom));
  endtask

  initial begin
    logic [31:0] ts_set[4];
    logic [31:0] sr_set[4];
    int cap;
    ts_set = '{TS_RESET, 32'd65536, 32'd0, 32'd0};
    sr_set = '{SR_RESET, 32'd0, 32'd65535, 32'd0};
    ts_set[3] = $urandom_range(65536);
    sr_set[3] = $urandom_range(4095);
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(OP_STEP, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 0);
    send(OP_APPEND, 0, 0, 0, 0, 0, 0, 31'h7fff_ffff);
    send(OP_STEP, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send(OP_STEP, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
    send(OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    send(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
         32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++)
      send(OP_APPEND, 32'h8000_0000 + i * 32'h0100_0000, 32'h7fff_ffff - i,
           (i - 4) * 32'h0001_0000, 0, 0, 0, 31'h0001_0000 << (i % 4));
    send(OP_STEP, 32'h0000_0040, 32'hffff_0000, 32'h0000_0100,
         32'h0000_1000, 32'hffff_f000, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send(OP_STEP, 32'h1234_5678, 32'hedcb_a988, 0, 32'h0001_0000, 0, 32'hffff_0000, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_TS, ts_set[ph]);
      reg_write(REG_SR, sr_set[ph]);
      send_idle_pct = (ph == 1) ? 58 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 11 : 0;
      for (int n = 0; n < 107; n++) begin
        cap = ($urandom_range(19) == 0) ? MAX_CENTERS_DEF : 3;
        if (ph == 2 && n == 50) begin
          hold_len = 7000;
          hold_req++;
          repeat (4) send(OP_STEP, rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), 0);
        end
        if (n == 60 && $urandom_range(1)) drain();
        random_item(cap);
      end
      drain();
    end

    $display("sent %0d items, checked %0d body results over four register settings",
             items_sent, bodies_checked);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/pgbs_pkg.sv
src/pgbs_regs.sv
src/pgbs_ctrl.sv
src/pgbs_datapath.sv
src/point_gravity_body_step.sv
src/pgbs_checker.sv
bench/gravity_checker.sv
bench/testbench.sv
